// ===== rtl/core/ou8n_pkg.sv =====
// Shared types and constants for the oversampled 8N1 UART core.
package ou8n_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned BITS_W = 4;
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 16;

   // start, eight data bits; the stop bit time ends the frame
   localparam logic [BITS_W-1:0] FRAME_BITS = 4'd9;
   localparam logic [BYTE_W-1:0] TICKS_PER_BIT_RESET = 8'd3;
   localparam logic [BYTE_W-1:0] START_DELAY_RESET = 8'd4;

   typedef enum logic {
      CSR_TICKS_PER_BIT = 1'b0,
      CSR_START_DELAY = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              active;
      logic [BITS_W-1:0] bits_left;
   } rx_status_type;

   typedef struct packed {
      logic active;
      logic done;
   } tx_status_type;

endpackage

// ===== rtl/core/ou8n_rx.sv =====
// Receiver: start detection, bit-time counting and byte assembly, one tick per item.
module ou8n_rx
   import ou8n_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              line,
   input  logic              take,
   input  logic [BYTE_W-1:0] ticks_per_bit,
   input  logic [BYTE_W-1:0] start_delay,
   output logic              ready_next,
   output logic [BYTE_W-1:0] value_next,
   output rx_status_type     status
);

   logic              active_ff, active_in;
   logic [BYTE_W-1:0] count_ff, count_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic [BYTE_W-1:0] shift_ff, shift_in;
   logic [BYTE_W-1:0] holding_ff, holding_in;
   logic              full_ff, full_in;
   logic [BYTE_W-1:0] count_dec;
   logic [BITS_W-1:0] bits_dec;

   always_comb begin
      count_dec = count_ff - 1'b1;
      bits_dec = bits_ff - 1'b1;
      active_in = active_ff;
      count_in = count_ff;
      bits_in = bits_ff;
      shift_in = shift_ff;
      holding_in = holding_ff;
      // host take acts before the tick, so a byte latched now still shows ready
      full_in = full_ff & ~take;
      if (active_ff) begin
         count_in = count_dec;
         if (count_dec == '0) begin
            count_in = ticks_per_bit;
            bits_in = bits_dec;
            if (bits_dec == '0) begin
               holding_in = shift_ff;
               active_in = 1'b0;
               full_in = 1'b1;
            end else begin
               shift_in = {line, shift_ff[BYTE_W-1:1]};
            end
         end
      end else if (!line) begin
         active_in = 1'b1;
         count_in = start_delay;
         bits_in = FRAME_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff <= '0;
         bits_ff <= '0;
         shift_ff <= '0;
         holding_ff <= '0;
         full_ff <= 1'b0;
      end else if (step) begin
         active_ff <= active_in;
         count_ff <= count_in;
         bits_ff <= bits_in;
         shift_ff <= shift_in;
         holding_ff <= holding_in;
         full_ff <= full_in;
      end
   end

   assign ready_next = full_in;
   assign value_next = holding_in;
   assign status.active = active_ff;
   assign status.bits_left = bits_ff;

endmodule

// ===== rtl/core/ou8n_tx.sv =====
// Transmitter: free-running bit divider and frame shifter, one tick per item.
module ou8n_tx
   import ou8n_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              send,
   input  logic [BYTE_W-1:0] send_value,
   input  logic [BYTE_W-1:0] ticks_per_bit,
   output logic              line_next,
   output logic              idle_next,
   output tx_status_type     status
);

   logic              active_ff, active_in;
   logic              done_ff, done_in;
   logic [BYTE_W-1:0] count_ff, count_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic [BYTE_W-1:0] holding_ff, holding_in;
   logic [BYTE_W-1:0] shift_ff, shift_in;
   logic              level_ff, level_in;
   logic [BYTE_W-1:0] count_dec;
   logic [BITS_W-1:0] bits_dec;
   logic              load;

   always_comb begin
      load = send & done_ff;
      count_dec = count_ff - 1'b1;
      bits_dec = bits_ff - 1'b1;
      active_in = active_ff | load;
      done_in = done_ff & ~load;
      holding_in = load ? send_value : holding_ff;
      count_in = count_dec;
      bits_in = bits_ff;
      shift_in = shift_ff;
      level_in = level_ff;
      // divider runs whether or not a frame is in flight
      if (count_dec == '0) begin
         count_in = ticks_per_bit;
         if (active_in) begin
            if (bits_ff == '0) begin
               level_in = 1'b0;
               shift_in = holding_in;
               bits_in = FRAME_BITS;
            end else begin
               bits_in = bits_dec;
               if (bits_dec == '0) begin
                  level_in = 1'b1;
                  active_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  level_in = shift_ff[0];
                  shift_in = {1'b0, shift_ff[BYTE_W-1:1]};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff <= 1'b1;
         count_ff <= '0;
         bits_ff <= '0;
         holding_ff <= '0;
         shift_ff <= '0;
         level_ff <= 1'b1;
      end else if (step) begin
         active_ff <= active_in;
         done_ff <= done_in;
         count_ff <= count_in;
         bits_ff <= bits_in;
         holding_ff <= holding_in;
         shift_ff <= shift_in;
         level_ff <= level_in;
      end
   end

   assign line_next = level_in;
   assign idle_next = done_in;
   assign status.active = active_ff;
   assign status.done = done_ff;

endmodule

// ===== rtl/core/oversampled_uart_8n1_core.sv =====
// Top level of the oversampled 8N1 UART core: handshake, config registers, result register.
//
//  channel | dir | signals                      | contents
//  req     | in  | req_tvalid/tready/tdata[15:0] | one oversampling tick
//  rsp     | out | rsp_tvalid/tready/tdata[15:0] | line and status after that tick
//  csr     | in  | csr_we/csr_index/csr_wdata    | ticks_per_bit, start_delay
//
// One item per cycle unless stalled; the result appears in the cycle after acceptance.
// The only loop is the per-tick state update in the rx and tx units.
// req_tready is high while the result register is empty or being drained.
// Synchronous reset restores the line idle-high, tx idle and default config.
module oversampled_uart_8n1_core
   import ou8n_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [0] rx_line, [1] send_request, [9:2] send_value, [10] take_received, rest zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] tx_line, [1] tx_idle, [2] rx_ready, [10:3] rx_value, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [BYTE_W-1:0]     csr_wdata
);

   logic [BYTE_W-1:0]     ticks_per_bit_ff;
   logic [BYTE_W-1:0]     start_delay_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  accept;
   logic                  rx_ready_next;
   logic [BYTE_W-1:0]     rx_value_next;
   logic                  tx_line_next;
   logic                  tx_idle_next;
   rx_status_type         rx_status;
   tx_status_type         tx_status;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_bit_ff <= TICKS_PER_BIT_RESET;
         start_delay_ff <= START_DELAY_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TICKS_PER_BIT: ticks_per_bit_ff <= csr_wdata;
            CSR_START_DELAY:   start_delay_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ou8n_rx u_rx (
      .clock         (clock),
      .reset         (reset),
      .step          (accept),
      .line          (req_tdata[0]),
      .take          (req_tdata[10]),
      .ticks_per_bit (ticks_per_bit_ff),
      .start_delay   (start_delay_ff),
      .ready_next    (rx_ready_next),
      .value_next    (rx_value_next),
      .status        (rx_status)
   );

   ou8n_tx u_tx (
      .clock         (clock),
      .reset         (reset),
      .step          (accept),
      .send          (req_tdata[1]),
      .send_value    (req_tdata[9:2]),
      .ticks_per_bit (ticks_per_bit_ff),
      .line_next     (tx_line_next),
      .idle_next     (tx_idle_next),
      .status        (tx_status)
   );

   assign rsp_valid_in = accept | (rsp_valid_ff & ~rsp_tready);
   assign rsp_data_in = {5'd0, rx_value_next, rx_ready_next, tx_idle_next, tx_line_next};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   // tx is either sending a frame or done, never both or neither
   a_tx_state: assert property (@(posedge clock) disable iff (reset)
      tx_status.active != tx_status.done)
      else $error("tx active and done flags disagree");

   a_rx_bits: assert property (@(posedge clock) disable iff (reset)
      rx_status.bits_left <= FRAME_BITS)
      else $error("rx bit counter out of frame range");

   // an idle receiver has used up its whole frame
   a_rx_idle_bits: assert property (@(posedge clock) disable iff (reset)
      !rx_status.active |-> rx_status.bits_left == '0)
      else $error("rx idle with bits left");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted item produced no result");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_valid_ff)
      else $error("input stalled with empty result register");

endmodule
